[sv/abs_pkg.sv]
// ----------------------------------------------------------------------------
// abs_pkg: shared types and constants of the alternating-bit sender
// Input beat, result beat, front-to-back command and store write port.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int LEN_W  = 7;   // holds a packet length up to 127
  localparam int ADDR_W = 6;   // addresses a store of up to 64 bytes

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_TIMER = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  localparam logic OUT_BYTE = 1'b0;
  localparam logic OUT_STOP = 1'b1;

  typedef enum logic {
    CMD_EMIT = 1'b0,
    CMD_STOP = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_FETCH = 2'd1,
    B_EMIT  = 2'd2
  } bst_t;

  typedef struct packed {
    act_t               action;
    logic signed [7:0]  data_byte;
    logic               byte_last;
    logic signed [31:0] ack_seq;
    logic signed [31:0] ack_number;
    logic signed [31:0] ack_check;
  } in_t;

  typedef struct packed {
    logic               out_kind;
    logic               pkt_seq;
    logic signed [31:0] pkt_check;
    logic signed [7:0]  pkt_byte;
    logic               run_last;
  } out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              seq;
    logic [31:0]       check;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_idle;
  } stat_t;

endpackage

[sv/abs_front.sv]
// ----------------------------------------------------------------------------
// abs_front: input side of the alternating-bit sender
// Classifies beats, tracks the protocol phase, stores and sums the message,
// checks acks and queues emit / stop commands for the back end.
// ----------------------------------------------------------------------------
module abs_front #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  abs_pkg::in_t  in_data,
  input  abs_pkg::stat_t stat,
  output logic          push,
  output abs_pkg::cmd_t cmd,
  output abs_pkg::wr_t  wr
);
  import abs_pkg::*;

  localparam int LW = $clog2(PAYLOAD_BYTES + 1);

  logic          seq_r, seq_nxt;
  logic          wait_r, wait_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic          taken_r, taken_nxt;
  logic [31:0]   check_r, check_nxt;
  logic [LW-1:0] len_r, len_nxt;

  logic          acc;
  logic          taken_now;
  logic          room;
  logic [31:0]   sum_add;
  logic [LW-1:0] idx_inc;
  logic [31:0]   check_new;
  logic          ack_ok;

  assign in_ready = !stat.q_full &&
                    (in_data.action != ACT_BYTE || (stat.q_empty && stat.back_idle));
  assign acc = in_valid && in_ready;

  always_comb begin
    taken_now = (idx_r == '0) ? !wait_r : taken_r;
    room      = idx_r < LW'(PAYLOAD_BYTES);
    sum_add   = (taken_now && room) ?
                sum_r + {{24{in_data.data_byte[7]}}, in_data.data_byte} : sum_r;
    idx_inc   = room ? idx_r + 1'b1 : idx_r;
    check_new = ~({31'd0, seq_r} + sum_add);
    ack_ok    = (~(in_data.ack_seq + in_data.ack_number) == in_data.ack_check) &&
                (in_data.ack_number == {31'd0, seq_r});
  end

  always_comb begin
    seq_nxt   = seq_r;
    wait_nxt  = wait_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    taken_nxt = taken_r;
    check_nxt = check_r;
    len_nxt   = len_r;
    push      = 1'b0;
    cmd       = '0;
    wr        = '0;
    if (acc) begin
      unique case (in_data.action)
        ACT_BYTE: begin
          if (taken_now && room) begin
            wr.en   = 1'b1;
            wr.addr = ADDR_W'(idx_r);
            wr.data = in_data.data_byte;
          end
          if (!in_data.byte_last) begin
            idx_nxt   = idx_inc;
            taken_nxt = taken_now;
            sum_nxt   = sum_add;
          end else begin
            idx_nxt   = '0;
            taken_nxt = 1'b0;
            sum_nxt   = '0;
            if (taken_now) begin
              check_nxt = check_new;
              len_nxt   = idx_inc;
              wait_nxt  = 1'b1;
              push      = 1'b1;
              cmd.kind  = CMD_EMIT;
              cmd.seq   = seq_r;
              cmd.check = check_new;
              cmd.len   = LEN_W'(idx_inc);
            end
          end
        end
        ACT_ACK: begin
          if (wait_r && ack_ok) begin
            seq_nxt   = !seq_r;
            wait_nxt  = 1'b0;
            push      = 1'b1;
            cmd.kind  = CMD_STOP;
            cmd.seq   = seq_r;
          end
        end
        ACT_TIMER: begin
          if (wait_r) begin
            push      = 1'b1;
            cmd.kind  = CMD_EMIT;
            cmd.seq   = seq_r;
            cmd.check = check_r;
            cmd.len   = LEN_W'(len_r);
          end
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 1'b0;
      wait_r  <= 1'b0;
      idx_r   <= '0;
      sum_r   <= '0;
      taken_r <= 1'b0;
      check_r <= '0;
      len_r   <= '0;
    end else begin
      seq_r   <= seq_nxt;
      wait_r  <= wait_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
      check_r <= check_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

[sv/abs_queue.sv]
// ----------------------------------------------------------------------------
// abs_queue: two-entry command queue between front and back
// ----------------------------------------------------------------------------
module abs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  abs_pkg::cmd_t din,
  input  logic          pop,
  output abs_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);
  import abs_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/abs_back.sv]
// ----------------------------------------------------------------------------
// abs_back: output side of the alternating-bit sender
// Holds the payload store, plays queued commands out as packet runs or
// stop beats through a registered output stage.
// ----------------------------------------------------------------------------
module abs_back #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  abs_pkg::wr_t  wr,
  input  abs_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          back_idle,
  output logic          out_valid,
  input  logic          out_ready,
  output abs_pkg::out_t out_data
);
  import abs_pkg::*;

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [7:0]    mem [PAYLOAD_BYTES];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;

  bst_t          state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          out_valid_r;
  out_t          out_r, out_nxt;

  logic          out_free;
  logic          load;
  logic          is_last;
  logic [7:0]    byte_sel;

  assign out_free  = !out_valid_r || out_ready;
  assign is_last   = idx_r == AW'(PAYLOAD_BYTES - 1);
  assign byte_sel  = (LEN_W'(idx_r) < cmd_r.len) ? rd_q : 8'd0;
  assign back_idle = state_r == B_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty && head.kind == CMD_EMIT) state_nxt = B_FETCH;
      B_FETCH: state_nxt = B_EMIT;
      B_EMIT:  if (out_free && is_last) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    load    = 1'b0;
    out_nxt = out_r;
    idx_nxt = idx_r;
    cmd_nxt = cmd_r;
    rd_addr = idx_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.kind == CMD_STOP) begin
            if (out_free) begin
              pop               = 1'b1;
              load              = 1'b1;
              out_nxt.out_kind  = OUT_STOP;
              out_nxt.pkt_seq   = head.seq;
              out_nxt.pkt_check = '0;
              out_nxt.pkt_byte  = '0;
              out_nxt.run_last  = 1'b1;
            end
          end else begin
            pop     = 1'b1;
            cmd_nxt = head;
            idx_nxt = '0;
          end
        end
      end
      B_FETCH: begin
      end
      B_EMIT: begin
        if (out_free) begin
          load              = 1'b1;
          out_nxt.out_kind  = OUT_BYTE;
          out_nxt.pkt_seq   = cmd_r.seq;
          out_nxt.pkt_check = cmd_r.check;
          out_nxt.pkt_byte  = byte_sel;
          out_nxt.run_last  = is_last;
          if (!is_last) begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[sv/alternating_bit_sender_top.sv]
// ----------------------------------------------------------------------------
// alternating_bit_sender_top: alternating-bit protocol sender
// Input beats carry message bytes, acks or timer expiries; result beats
// carry packet bytes (a run implies a timer start) or a stop-timer command.
//
// Usage:
//   in_*  : valid/ready. A message byte beat is taken one per cycle while no
//           packet run is queued or playing out; ack and timer beats are
//           taken whenever the two-entry command queue has room.
//   out_* : valid/ready behind an output register. A packet run is
//           PAYLOAD_BYTES beats, one per cycle when out_ready stays high,
//           starting after the queue pop and the store read-ahead. A stop
//           beat passes through the queue and the output register.
//   Rate  : one packet byte per cycle while out_ready stays high, set by the
//           single read port of the payload store; a run start adds the queue
//           pop and the store read-ahead.
//   Stall : out_ready low holds the current result beat; the back end stops,
//           the queue fills and in_ready drops once it is full.
//   Reset : idle expecting sequence 0, sums and lengths cleared; the payload
//           store is not cleared.
// ----------------------------------------------------------------------------
module alternating_bit_sender_top #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  abs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output abs_pkg::out_t out_data
);
  import abs_pkg::*;

  stat_t stat;
  logic  push;
  logic  pop;
  cmd_t  cmd;
  cmd_t  head;
  wr_t   wr;
  logic  q_full;
  logic  q_empty;
  logic  back_idle;

  assign stat.q_full    = q_full;
  assign stat.q_empty   = q_empty;
  assign stat.back_idle = back_idle;

  abs_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .cmd      (cmd),
    .wr       (wr)
  );

  abs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  abs_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .back_idle (back_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (q_empty && back_idle))
    else $error("payload store written while a run is pending");

  a_stop_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == OUT_STOP) |->
      (out_data.run_last && out_data.pkt_byte == 8'sd0 && out_data.pkt_check == 32'sd0))
    else $error("malformed stop beat");

endmodule
